FILE: hw/rtl/gwwa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gwwa_pkg
// Shared types and constants for the greedy word wrapper.
// ----------------------------------------------------------------------------
package gwwa_pkg;

    localparam int DATA_W            = 8;
    localparam int MW_W              = 5;
    localparam int FILL_W            = 7;
    localparam int CFG_IDX_W         = 1;
    localparam int STORE_DEPTH_DEF   = 32;
    localparam int INDENT_WIDTH_DEF  = 4;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [DATA_W-1:0] SPACE_BYTE   = 8'h20;
    localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [DATA_W-1:0] TAB_BYTE     = 8'h09;
    localparam logic [DATA_W-1:0] CR_BYTE      = 8'h0D;

    localparam logic [MW_W-1:0] MAX_WIDTH_RESET = 5'd30;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ALIGN = 1'd1;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_BLANK,
        KIND_NEWLINE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] data;
    } q_item_t;

    typedef struct packed {
        logic [MW_W-1:0] max_width;
        logic            right_align;
    } cfg_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LINE_RD,
        ST_LINE_OUT,
        ST_NEWLINE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SPACE
    } state_t;

    function automatic logic is_blank(input logic [DATA_W-1:0] b);
        return (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/greedy_word_wrap_align.sv
// A word byte is written to the word RAM when the idle state pops it from the queue; on a wrap
// the line is read back through ST_LINE_RD and ST_LINE_OUT, after any pad spaces from ST_PAD.
// Word bytes are stored as they are popped; each byte copied into the line RAM takes a read and
// a write state, and each line byte emitted takes a RAM read and then the output register.
// The sustained rate per character is set by the single read port of each RAM.
// Reset: synchronous active-low aresetn empties the queue, drops any partial word and
// opens a new line with its indent; max_width returns to 30 and right_align to 0.
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_word_wrap_align
// Greedy word wrapper with optional right alignment, one byte per item.
// ----------------------------------------------------------------------------
module greedy_word_wrap_align #(
    parameter int STORE_DEPTH  = gwwa_pkg::STORE_DEPTH_DEF,
    parameter int INDENT_WIDTH = gwwa_pkg::INDENT_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [gwwa_pkg::DATA_W-1:0]      s_tdata,   // text_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [gwwa_pkg::DATA_W-1:0]      m_tdata,   // out_byte
    output logic                                  m_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [gwwa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gwwa_pkg::MW_W-1:0]        cfg_wdata
);
    import gwwa_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    q_head_t q_head;
    logic    q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_MAX_WIDTH:   cfg_next.max_width   = cfg_wdata;
                REG_RIGHT_ALIGN: cfg_next.right_align = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_width   <= MAX_WIDTH_RESET;
            cfg_reg.right_align <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gwwa_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    gwwa_back #(
        .STORE_DEPTH  (STORE_DEPTH),
        .INDENT_WIDTH (INDENT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/gwwa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gwwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gwwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/gwwa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gwwa_front
// Accepts input items, classifies each byte, and queues it for the back end.
// ----------------------------------------------------------------------------
module gwwa_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [gwwa_pkg::DATA_W-1:0]   s_tdata,
    output gwwa_pkg::q_head_t                  q_head,
    input  wire logic                          q_pop
);
    import gwwa_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_L = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

    q_item_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push;
    logic           pop;
    q_item_t        in_item;

    assign s_tready = (count_reg != FULL_L);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != '0);

    always_comb begin
        in_item.data = s_tdata;
        if (s_tdata == NEWLINE_BYTE) begin
            in_item.kind = KIND_NEWLINE;
        end else if (is_blank(s_tdata)) begin
            in_item.kind = KIND_BLANK;
        end else begin
            in_item.kind = KIND_CHAR;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = slot_reg[rd_ptr_reg];

endmodule
`default_nettype wire

FILE: hw/rtl/gwwa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gwwa_back
// Builds words and lines in two RAMs and emits wrapped lines byte by byte.
// ----------------------------------------------------------------------------
module gwwa_back #(
    parameter int STORE_DEPTH  = gwwa_pkg::STORE_DEPTH_DEF,
    parameter int INDENT_WIDTH = gwwa_pkg::INDENT_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire gwwa_pkg::cfg_t                cfg,
    input  wire gwwa_pkg::q_head_t             q_head,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [gwwa_pkg::DATA_W-1:0]   m_tdata,
    output logic                               m_tlast
);
    import gwwa_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L    = LW'(STORE_DEPTH);
    localparam logic [LW-1:0] WORD_MAX_L = LW'(STORE_DEPTH - 2);
    localparam logic [LW-1:0] INDENT_L   = LW'(INDENT_WIDTH);

    state_t              state_reg, state_next;
    logic [LW-1:0]       ll_reg, ll_next;
    logic [LW-1:0]       wl_reg, wl_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [LW-1:0]       idx_reg, idx_next;
    logic [MW_W-1:0]     pad_reg, pad_next;
    logic                nl_reg, nl_next;
    logic                final_reg, final_next;
    logic                indent_reg, indent_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;

    logic                can_load;
    logic                pop;
    logic                item_ends_word;
    logic [FILL_W-1:0]   total;
    logic                fits;
    logic [FILL_W-1:0]   mw_ext;
    logic [FILL_W-1:0]   ll_ext;
    logic [FILL_W-1:0]   pad_calc;
    logic                do_pad;
    logic [LW-1:0]       idx_inc;
    state_t              flush_start;
    logic [DATA_W-1:0]   line_byte;

    logic                word_we;
    logic                word_re;
    logic [DATA_W-1:0]   word_rdata;
    logic                line_we;
    logic                line_re;
    logic [DATA_W-1:0]   line_wdata;
    logic [DATA_W-1:0]   line_rdata;

    assign can_load       = !out_valid_reg || m_tready;
    assign pop            = (state_reg == ST_IDLE) && q_head.valid;
    assign q_pop          = pop;
    assign item_ends_word = (q_head.item.kind != KIND_CHAR) && (wl_reg != '0);
    assign total          = fill_reg + FILL_W'(wl_reg) + FILL_W'(1);
    assign mw_ext         = FILL_W'(cfg.max_width);
    assign fits           = total < mw_ext;
    assign ll_ext         = FILL_W'(ll_reg);
    assign pad_calc       = mw_ext - ll_ext;
    assign do_pad         = cfg.right_align && (mw_ext > ll_ext);
    assign idx_inc        = idx_reg + 1'b1;
    assign flush_start    = (ll_reg == '0) ? ST_NEWLINE : ST_LINE_RD;
    assign line_byte      = (indent_reg && (idx_reg < INDENT_L)) ? SPACE_BYTE : line_rdata;

    assign word_we    = pop && (q_head.item.kind == KIND_CHAR) && (wl_reg < WORD_MAX_L);
    assign word_re    = (state_reg == ST_COPY_RD);
    assign line_we    = ((state_reg == ST_COPY_WR) || (state_reg == ST_SPACE)) &&
                        (ll_reg < DEPTH_L);
    assign line_re    = (state_reg == ST_LINE_RD);
    assign line_wdata = (state_reg == ST_SPACE) ? SPACE_BYTE : word_rdata;

    gwwa_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_word_ram (
        .aclk  (aclk),
        .we    (word_we),
        .waddr (wl_reg[AW-1:0]),
        .wdata (q_head.item.data),
        .re    (word_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (word_rdata)
    );

    gwwa_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (ll_reg[AW-1:0]),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (line_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    if (item_ends_word) begin
                        if (fits) begin
                            state_next = ST_COPY_RD;
                        end else if (do_pad && (pad_calc != '0)) begin
                            state_next = ST_PAD;
                        end else begin
                            state_next = flush_start;
                        end
                    end else if (q_head.item.kind == KIND_NEWLINE) begin
                        state_next = flush_start;
                    end
                end
            end
            ST_PAD: begin
                if (can_load && (pad_reg == MW_W'(1))) begin
                    state_next = flush_start;
                end
            end
            ST_LINE_RD: begin
                state_next = ST_LINE_OUT;
            end
            ST_LINE_OUT: begin
                if (can_load) begin
                    state_next = (idx_inc == ll_reg) ? ST_NEWLINE : ST_LINE_RD;
                end
            end
            ST_NEWLINE: begin
                if (can_load) begin
                    state_next = final_reg ? ST_IDLE : ST_COPY_RD;
                end
            end
            ST_COPY_RD: begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                state_next = (idx_inc == wl_reg) ? ST_SPACE : ST_COPY_RD;
            end
            ST_SPACE: begin
                state_next = nl_reg ? ST_LINE_RD : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb begin
        ll_next        = ll_reg;
        wl_next        = wl_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        pad_next       = pad_reg;
        nl_next        = nl_reg;
        final_next     = final_reg;
        indent_next    = indent_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (line_we) begin
            ll_next = ll_reg + 1'b1;
        end
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    nl_next  = (q_head.item.kind == KIND_NEWLINE);
                    idx_next = '0;
                    pad_next = pad_calc[MW_W-1:0];
                    if (word_we) begin
                        wl_next = wl_reg + 1'b1;
                    end
                    if (item_ends_word) begin
                        final_next = 1'b0;
                        fill_next  = fits ? total : FILL_W'(wl_reg);
                    end else begin
                        final_next = 1'b1;
                    end
                end
            end
            ST_PAD: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = SPACE_BYTE;
                    out_last_next  = 1'b0;
                    pad_next       = pad_reg - 1'b1;
                end
            end
            ST_LINE_OUT: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = line_byte;
                    out_last_next  = 1'b0;
                    idx_next       = idx_inc;
                end
            end
            ST_NEWLINE: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = NEWLINE_BYTE;
                    out_last_next  = final_reg || !nl_reg;
                    idx_next       = '0;
                    if (final_reg) begin
                        ll_next     = INDENT_L;
                        indent_next = 1'b1;
                        fill_next   = FILL_W'(INDENT_WIDTH);
                    end else begin
                        ll_next     = '0;
                        indent_next = 1'b0;
                    end
                end
            end
            ST_COPY_WR: begin
                idx_next = idx_inc;
            end
            ST_SPACE: begin
                wl_next    = '0;
                idx_next   = '0;
                final_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ll_reg        <= INDENT_L;
            wl_reg        <= '0;
            fill_reg      <= FILL_W'(INDENT_WIDTH);
            indent_reg    <= 1'b1;
            nl_reg        <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ll_reg        <= ll_next;
            wl_reg        <= wl_next;
            fill_reg      <= fill_next;
            indent_reg    <= indent_next;
            nl_reg        <= nl_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
        idx_reg      <= idx_next;
        pad_reg      <= pad_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/gwwa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gwwa_checker
// Port-level checks for the word wrapper, bound to the top level.
// ----------------------------------------------------------------------------
module gwwa_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [gwwa_pkg::DATA_W-1:0]      s_tdata,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [gwwa_pkg::DATA_W-1:0]      m_tdata,
    input wire logic                             m_tlast
);
    import gwwa_pkg::*;

    // nothing leaves the block right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    // the last item of a run always closes a line
    a_last_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == NEWLINE_BYTE)
        else $error("tlast item is not a newline");

    // tabs, vertical tabs, form feeds and carriage returns never pass through
    a_no_blank_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata == 8'h09 || m_tdata == 8'h0B ||
                       m_tdata == 8'h0C || m_tdata == 8'h0D))
        else $error("whitespace control byte in output");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("stalled input item changed");

endmodule

bind greedy_word_wrap_align gwwa_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams text bytes into the word wrapper under random backpressure on
// both sides and compares every output byte and its tlast against an
// in-bench model of the greedy wrap. The run covers a short directed opening
// and then random sentences and noise under several width and alignment
// settings, including widths outside the nominal range.
// ----------------------------------------------------------------------------
module tb_top;

    import gwwa_pkg::*;

    localparam int LINE_DEPTH = STORE_DEPTH_DEF;
    localparam int WORD_LIMIT = STORE_DEPTH_DEF - 2;
    localparam int BURST_MAX  = 64;
    localparam int PHASES     = 8;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              last;
    } out_byte_t;

    class wrap_tracker;
        out_byte_t         expected_text[$];
        logic [DATA_W-1:0] line_buf [LINE_DEPTH];
        logic [5:0]        line_len;
        logic [DATA_W-1:0] word_buf [LINE_DEPTH];
        logic [5:0]        word_len;
        logic [FILL_W-1:0] fill;
        logic [MW_W-1:0]   width_lim;
        logic              right_pad;
        logic [DATA_W-1:0] burst [BURST_MAX];
        int                burst_n;
        int                errors;
        int                bytes_in;
        int                bytes_out;

        function new();
            foreach (line_buf[i]) line_buf[i] = '0;
            foreach (word_buf[i]) word_buf[i] = '0;
            word_len  = '0;
            width_lim = MAX_WIDTH_RESET;
            right_pad = 1'b0;
            errors    = 0;
            bytes_in  = 0;
            bytes_out = 0;
            open_line();
        endfunction

        function bit is_gap_char(logic [DATA_W-1:0] b);
            return (b == SPACE_BYTE) || (b >= TAB_BYTE && b <= CR_BYTE);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MW_W-1:0] v);
            case (idx)
                REG_MAX_WIDTH: begin
                    width_lim = v;
                end
                REG_RIGHT_ALIGN: begin
                    right_pad = v[0];
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        function void put(logic [DATA_W-1:0] b);
            if (burst_n < BURST_MAX) begin
                burst[burst_n] = b;
                burst_n++;
            end
        endfunction

        function void line_add(logic [DATA_W-1:0] b);
            if (line_len < LINE_DEPTH) begin
                line_buf[line_len[4:0]] = b;
                line_len++;
            end
        endfunction

        function void open_line();
            line_len = '0;
            for (int i = 0; i < INDENT_WIDTH_DEF; i++) line_add(SPACE_BYTE);
            fill = FILL_W'(INDENT_WIDTH_DEF);
        endfunction

        function void flush_line(bit pad);
            if (pad && int'(width_lim) > int'(line_len)) begin
                for (int i = int'(line_len); i < int'(width_lim); i++) put(SPACE_BYTE);
            end
            for (int i = 0; i < int'(line_len); i++) put(line_buf[i]);
            put(NEWLINE_BYTE);
        endfunction

        function void place_word();
            for (int i = 0; i < int'(word_len); i++) line_add(word_buf[i]);
            line_add(SPACE_BYTE);
        endfunction

        function void end_word();
            int total;
            if (word_len == 0) return;
            total = int'(fill) + int'(word_len) + 1;
            if (total < int'(width_lim)) begin
                place_word();
                fill = FILL_W'(total);
            end else begin
                flush_line(right_pad);
                line_len = '0;
                place_word();
                fill = FILL_W'(word_len);
            end
            word_len = '0;
        endfunction

        // one accepted text byte: advance the wrap state, queue the bytes it releases
        function void note_input(logic [DATA_W-1:0] b);
            burst_n = 0;
            bytes_in++;
            if (is_gap_char(b)) begin
                end_word();
                if (b == NEWLINE_BYTE) begin
                    flush_line(1'b0);
                    open_line();
                end
            end else if (word_len < WORD_LIMIT) begin
                word_buf[word_len[4:0]] = b;
                word_len++;
            end
            for (int i = 0; i < burst_n; i++)
                expected_text.push_back('{data: burst[i], last: (i == burst_n - 1)});
        endfunction

        task log_mismatch(string msg);
            if (errors < 30) $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [DATA_W-1:0] data, logic last);
            out_byte_t exp_b;
            bytes_out++;
            if (expected_text.size() == 0) begin
                log_mismatch($sformatf("unexpected byte %02h last %0b", data, last));
                return;
            end
            exp_b = expected_text.pop_front();
            if (data !== exp_b.data)
                log_mismatch($sformatf("byte %0d: data %02h, want %02h",
                                       bytes_out, data, exp_b.data));
            if (last !== exp_b.last)
                log_mismatch($sformatf("byte %0d: tlast %0b, want %0b",
                                       bytes_out, last, exp_b.last));
        endtask
    endclass

    localparam logic [DATA_W-1:0] OPENING [21] = '{
        8'h00, 8'hFF, 8'h20, 8'h41, 8'h09, 8'h80, 8'h7F, 8'h0B, 8'h0B, 8'h62,
        8'h0C, 8'h63, 8'h0D, 8'h20, 8'h20, 8'h64, 8'h0A, 8'h0A, 8'h01, 8'hFE,
        8'h0A
    };
    localparam logic [MW_W-1:0] PHASE_WIDTH [PHASES] = '{
        5'd12, 5'd5, 5'd30, 5'd31, 5'd0, 5'd20, 5'd5, 5'd17
    };
    localparam bit PHASE_ALIGN [PHASES] = '{1, 0, 1, 1, 1, 0, 1, 0};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [MW_W-1:0]       cfg_wdata = '0;

    wrap_tracker tracker = new();
    bit src_steady;
    bit sink_steady;
    int stall_left;
    int sink_roll;

    greedy_word_wrap_align u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tlast);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (sink_steady) begin
                m_tready <= 1'b1;
            end else begin
                sink_roll = $urandom_range(0, 99);
                if (sink_roll < 65) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready   <= 1'b0;
                    stall_left = (sink_roll < 93) ? $urandom_range(0, 2)
                                                  : $urandom_range(8, 24);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (src_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [DATA_W-1:0] word_char();
        logic [DATA_W-1:0] b;
        do b = DATA_W'($urandom_range(0, 255)); while (tracker.is_gap_char(b));
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] gap_char();
        case ($urandom_range(0, 5))
            0:       return TAB_BYTE;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return CR_BYTE;
            default: return SPACE_BYTE;
        endcase
    endfunction

    // returns at the edge where the item was taken; tvalid stays high
    task automatic send_byte(input logic [DATA_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        tracker.note_input(b);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MW_W-1:0] v);
        cfg_index <= idx;
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tracker.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic send_word(input int len);
        for (int i = 0; i < len; i++) send_byte(word_char());
    endtask

    task automatic text_phase(input int n_items, input int hold_at, input bit long_first);
        int start;
        int r;
        int len;
        start = tracker.bytes_in;
        if (long_first) begin
            send_word(33);
            send_byte(SPACE_BYTE);
        end
        while (tracker.bytes_in - start < n_items) begin
            if (hold_at > 0 && tracker.bytes_in - start >= hold_at) begin
                drain();
                hold_at = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 85) begin
                r   = $urandom_range(0, 99);
                len = (r < 70) ? $urandom_range(1, 7) :
                      (r < 95) ? $urandom_range(8, 16) : $urandom_range(28, 36);
                send_word(len);
                r = $urandom_range(0, 99);
                if (r < 78) begin
                    send_byte(SPACE_BYTE);
                end else if (r < 90) begin
                    send_byte(NEWLINE_BYTE);
                end else begin
                    repeat ($urandom_range(2, 3)) send_byte(gap_char());
                end
            end else begin
                send_byte(DATA_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(OPENING); i++) send_byte(OPENING[i]);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            // queued items with no output may still be working through the word copy
            repeat (256) @(posedge aclk);
            write_reg(REG_MAX_WIDTH, PHASE_WIDTH[p]);
            write_reg(REG_RIGHT_ALIGN, MW_W'(PHASE_ALIGN[p]));
            src_steady  = (p == 2) || (p == 6);
            sink_steady = (p == 5) || (p == 6);
            text_phase(40, (p == 3) ? 20 : 0, (p == 0) || (p == 4));
        end

        drain();
        repeat (64) @(posedge aclk);
        $display("%0d text bytes sent over %0d width/alignment settings,",
                 tracker.bytes_in, PHASES + 1);
        $display("%0d output bytes compared, %0d errors", tracker.bytes_out, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/gwwa_pkg.sv
hw/rtl/gwwa_ram.sv
hw/rtl/gwwa_front.sv
hw/rtl/gwwa_back.sv
hw/rtl/greedy_word_wrap_align.sv
hw/rtl/gwwa_checker.sv
bench/tb_top.sv
